FILE: hw/rtl/rgoc_pkg.sv
// shared types, codes and constants of the range grid object classifier
package rgoc_pkg;

	localparam int IN_COLS   = 8;
	localparam int GRID_COLS = 8;
	localparam int SCAN_COLS = (GRID_COLS < IN_COLS) ? GRID_COLS : IN_COLS;
	localparam int DIST_W    = 12;
	localparam int CNT_W     = 16;
	localparam int ROW_W     = 3;

	// raw row / frame class
	localparam logic [1:0] CLS_EMPTY  = 2'd0;
	localparam logic [1:0] CLS_SINGLE = 2'd1;
	localparam logic [1:0] CLS_DOUBLE = 2'd2;

	// candidate / confirmed state
	localparam logic [1:0] ST_NONE   = 2'd0;
	localparam logic [1:0] ST_EMPTY  = 2'd1;
	localparam logic [1:0] ST_SINGLE = 2'd2;
	localparam logic [1:0] ST_DOUBLE = 2'd3;

	// lamp codes
	localparam logic [1:0] LED_OFF   = 2'd0;
	localparam logic [1:0] LED_RED   = 2'd1;
	localparam logic [1:0] LED_GREEN = 2'd2;
	localparam logic [1:0] LED_BLUE  = 2'd3;

	localparam logic [DIST_W-1:0] NEAR_THRESHOLD_RST = 12'd127;
	localparam logic [2:0]        GAP_MIN_RST        = 3'd3;
	localparam logic [2:0]        DOUBLE_VOTES_RST   = 3'd3;
	localparam logic [3:0]        CONFIRM_FRAMES_RST = 4'd3;
	localparam logic [7:0]        SINGLE_HOLD_RST    = 8'd50;

	localparam logic [3:0] RUN_MAX  = 4'd15;
	localparam logic [7:0] HOLD_MAX = 8'd255;

	localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

	typedef enum logic [2:0] {
		CFG_NEAR_THRESHOLD = 3'd0,
		CFG_GAP_MIN        = 3'd1,
		CFG_DOUBLE_VOTES   = 3'd2,
		CFG_CONFIRM_FRAMES = 3'd3,
		CFG_SINGLE_HOLD    = 3'd4
	} cfg_idx_t;

	typedef struct packed {
		logic [DIST_W-1:0] near_threshold;
		logic [2:0]        gap_min;
		logic [2:0]        double_votes;
		logic [3:0]        confirm_frames;
		logic [7:0]        single_hold_frames;
	} cfg_t;

	typedef struct packed {
		logic [1:0]       confirmed;
		logic [1:0]       led_select;
		logic             stop_flag;
		logic [CNT_W-1:0] empty_count;
		logic [CNT_W-1:0] single_count;
		logic [CNT_W-1:0] double_count;
	} status_t;

endpackage

FILE: hw/rtl/range_grid_object_classifier.sv
// top level of the range grid object classifier
//
//   channel  | direction | payload
//   ---------+-----------+---------------------------------------------------
//   s_axis   | in        | tuser row_index, tdata dist0..dist7
//   m_axis   | out       | tlast frame_done, tdata class, state and counters
//   cfg      | in        | write only, index 0..4, no wait
//
// one row is taken per cycle while the output is not stalled. its result
// leaves through the output register; while that stalls, a row in the input
// register waits there and stops the next one. the path between the two
// registers is the row scan or the frame vote, then the debounce update.
// reset clears valid and debounce state, sets stored rows to single and cfg to defaults.
module range_grid_object_classifier #(
	parameter int GRID_ROWS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [95:0] s_tdata,   // dist0 [11:0] .. dist7 [95:84]
	input  logic [2:0]  s_tuser,   // row_index [2:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,   // frame_class, confirmed, led_select, stop_flag,
	                               // empty_count, single_count, double_count, pad
	output logic        m_tlast,   // frame_done
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [11:0] cfg_wdata
);

	localparam logic [3:0] LAST_ROW = 4'(GRID_ROWS - 1);

	rgoc_pkg::cfg_t    cfg_q;
	rgoc_pkg::status_t status;

	logic        valid_s1;
	logic [2:0]  row_s1;
	logic [95:0] dist_s1;
	logic        out_valid_q;
	logic [55:0] out_data_q;
	logic        out_last_q;

	logic        advance;
	logic        is_store, is_frame;
	logic [1:0]  row_cls, frame_cls, cls_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.near_threshold     <= rgoc_pkg::NEAR_THRESHOLD_RST;
			cfg_q.gap_min            <= rgoc_pkg::GAP_MIN_RST;
			cfg_q.double_votes       <= rgoc_pkg::DOUBLE_VOTES_RST;
			cfg_q.confirm_frames     <= rgoc_pkg::CONFIRM_FRAMES_RST;
			cfg_q.single_hold_frames <= rgoc_pkg::SINGLE_HOLD_RST;
		end else if (cfg_we) begin
			case (rgoc_pkg::cfg_idx_t'(cfg_index))
				rgoc_pkg::CFG_NEAR_THRESHOLD: cfg_q.near_threshold     <= cfg_wdata;
				rgoc_pkg::CFG_GAP_MIN:        cfg_q.gap_min            <= cfg_wdata[2:0];
				rgoc_pkg::CFG_DOUBLE_VOTES:   cfg_q.double_votes       <= cfg_wdata[2:0];
				rgoc_pkg::CFG_CONFIRM_FRAMES: cfg_q.confirm_frames     <= cfg_wdata[3:0];
				rgoc_pkg::CFG_SINGLE_HOLD:    cfg_q.single_hold_frames <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s1 <= 1'b0;
		else if (s_tready) valid_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			row_s1  <= s_tuser;
			dist_s1 <= s_tdata;
		end
	end

	assign is_store = {1'b0, row_s1} < LAST_ROW;
	assign is_frame = {1'b0, row_s1} == LAST_ROW;

	rgoc_row_scan u_scan (
		.zone_dist      (dist_s1),
		.near_threshold (cfg_q.near_threshold),
		.gap_min        (cfg_q.gap_min),
		.row_cls        (row_cls)
	);

	rgoc_frame_vote #(.GRID_ROWS(GRID_ROWS)) u_vote (
		.clk          (clk),
		.arst_n       (arst_n),
		.wr_en        (advance && is_store),
		.row          (row_s1),
		.row_cls      (row_cls),
		.double_votes (cfg_q.double_votes),
		.frame_cls    (frame_cls)
	);

	rgoc_debounce u_deb (
		.clk       (clk),
		.arst_n    (arst_n),
		.upd_en    (advance),
		.frame_en  (is_frame),
		.frame_cls (frame_cls),
		.cfg       (cfg_q),
		.status    (status)
	);

	assign cls_out = is_frame ? frame_cls : rgoc_pkg::CLS_EMPTY;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (advance) out_valid_q <= 1'b1;
		else if (m_tready) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_last_q <= is_frame;
			out_data_q <= {1'b0, status.double_count, status.single_count,
				status.empty_count, status.stop_flag, status.led_select,
				status.confirmed, cls_out};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;

endmodule

FILE: hw/rtl/rgoc_row_scan.sv
// classifies one row of zone distances as empty, single or double
module rgoc_row_scan (
	input  logic [rgoc_pkg::IN_COLS*rgoc_pkg::DIST_W-1:0] zone_dist,
	input  logic [rgoc_pkg::DIST_W-1:0]                   near_threshold,
	input  logic [2:0]                                    gap_min,
	output logic [1:0]                                    row_cls
);

	always_comb begin
		logic       seen;
		logic       gap_ok;
		logic       dbl;
		logic       hit;
		logic [3:0] run;
		seen   = 1'b0;
		gap_ok = 1'b0;
		dbl    = 1'b0;
		run    = 4'd0;
		for (int c = 0; c < rgoc_pkg::SCAN_COLS; c++) begin
			hit = zone_dist[c*rgoc_pkg::DIST_W +: rgoc_pkg::DIST_W] <= near_threshold;
			if (hit) begin
				if (seen && gap_ok) dbl = 1'b1;
				seen = 1'b1;
				run  = 4'd0;
			end else if (seen) begin
				run = run + 4'd1;
				if (run >= {1'b0, gap_min}) gap_ok = 1'b1;
			end
		end
		if (dbl)
			row_cls = rgoc_pkg::CLS_DOUBLE;
		else if (seen)
			row_cls = rgoc_pkg::CLS_SINGLE;
		else
			row_cls = rgoc_pkg::CLS_EMPTY;
	end

endmodule

FILE: hw/rtl/rgoc_frame_vote.sv
// per-row class store and the frame vote over the stored rows
module rgoc_frame_vote #(
	parameter int GRID_ROWS = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         wr_en,
	input  logic [rgoc_pkg::ROW_W-1:0]   row,
	input  logic [1:0]                   row_cls,
	input  logic [2:0]                   double_votes,
	output logic [1:0]                   frame_cls
);

	localparam int NROWS = GRID_ROWS - 1;
	localparam int CW    = $clog2(GRID_ROWS);
	localparam int VW    = (CW > 3) ? CW : 3;

	logic [NROWS-1:0][1:0] row_class_q;
	logic [CW-1:0]         dbl_cnt;
	logic                  any_hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < NROWS; r++) row_class_q[r] <= rgoc_pkg::CLS_SINGLE;
		end else if (wr_en) begin
			for (int r = 0; r < NROWS; r++)
				if ({1'b0, row} == 4'(r)) row_class_q[r] <= row_cls;
		end
	end

	always_comb begin
		dbl_cnt = '0;
		any_hit = 1'b0;
		for (int r = 0; r < NROWS; r++) begin
			if (row_class_q[r] == rgoc_pkg::CLS_DOUBLE) dbl_cnt = dbl_cnt + CW'(1);
			if (row_class_q[r] != rgoc_pkg::CLS_EMPTY) any_hit = 1'b1;
		end
		if (VW'(dbl_cnt) >= VW'(double_votes))
			frame_cls = rgoc_pkg::CLS_DOUBLE;
		else if (any_hit)
			frame_cls = rgoc_pkg::CLS_SINGLE;
		else
			frame_cls = rgoc_pkg::CLS_EMPTY;
	end

endmodule

FILE: hw/rtl/rgoc_debounce.sv
// frame debounce: confirmation, single hold, lamp, stop flag and event counters
module rgoc_debounce (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    upd_en,
	input  logic                    frame_en,
	input  logic [1:0]              frame_cls,
	input  rgoc_pkg::cfg_t          cfg,
	output rgoc_pkg::status_t       status
);

	logic [1:0]                 cand_q, conf_q, prev_conf_q, hold_prev_q, led_q;
	logic [3:0]                 run_q;
	logic                       holding_q, stop_q;
	logic [7:0]                 hold_cnt_q;
	logic [rgoc_pkg::CNT_W-1:0] cnt_e_q, cnt_s_q, cnt_d_q;

	logic [1:0]                 cand_d, conf_d, prev_conf_d, hold_prev_d, led_d;
	logic [3:0]                 run_d;
	logic                       holding_d, stop_d;
	logic [7:0]                 hold_cnt_d;
	logic [rgoc_pkg::CNT_W-1:0] cnt_e_d, cnt_s_d, cnt_d_d;

	always_comb begin
		logic [1:0] st;
		cand_d      = cand_q;
		conf_d      = conf_q;
		prev_conf_d = prev_conf_q;
		hold_prev_d = hold_prev_q;
		led_d       = led_q;
		run_d       = run_q;
		holding_d   = holding_q;
		stop_d      = stop_q;
		hold_cnt_d  = hold_cnt_q;
		cnt_e_d     = cnt_e_q;
		cnt_s_d     = cnt_s_q;
		cnt_d_d     = cnt_d_q;
		st          = frame_cls + 2'd1;
		if (frame_en) begin
			if (st == cand_q) begin
				if (run_q < rgoc_pkg::RUN_MAX) run_d = run_q + 4'd1;
			end else begin
				cand_d = st;
				run_d  = 4'd1;
			end

			if (run_d >= cfg.confirm_frames && cand_d != conf_q) begin
				case (cand_d)
					rgoc_pkg::ST_SINGLE: begin
						holding_d   = 1'b1;
						hold_cnt_d  = 8'd0;
						hold_prev_d = conf_q;
						led_d       = rgoc_pkg::LED_OFF;
						prev_conf_d = conf_q;
						conf_d      = rgoc_pkg::ST_SINGLE;
					end
					rgoc_pkg::ST_DOUBLE: begin
						holding_d   = 1'b0;
						hold_cnt_d  = 8'd0;
						prev_conf_d = conf_q;
						conf_d      = rgoc_pkg::ST_DOUBLE;
						led_d       = rgoc_pkg::LED_BLUE;
						if (cnt_d_q != '1) cnt_d_d = cnt_d_q + rgoc_pkg::CNT_ONE;
						stop_d      = 1'b1;
					end
					default: begin
						// held single, unless it followed a double, is counted before the empty is confirmed
						if (holding_q) begin
							holding_d  = 1'b0;
							hold_cnt_d = 8'd0;
							led_d      = rgoc_pkg::LED_GREEN;
							if (hold_prev_q != rgoc_pkg::ST_DOUBLE && cnt_s_d != '1)
								cnt_s_d = cnt_s_d + rgoc_pkg::CNT_ONE;
						end
						// single between empties is taken back
						if (conf_q == rgoc_pkg::ST_SINGLE && prev_conf_q == rgoc_pkg::ST_EMPTY
							&& cnt_s_d != '0)
							cnt_s_d = cnt_s_d - rgoc_pkg::CNT_ONE;
						prev_conf_d = conf_q;
						conf_d      = rgoc_pkg::ST_EMPTY;
						led_d       = rgoc_pkg::LED_RED;
						if (cnt_e_q != '1) cnt_e_d = cnt_e_q + rgoc_pkg::CNT_ONE;
					end
				endcase
			end

			if (holding_d) begin
				if (hold_cnt_d < rgoc_pkg::HOLD_MAX) hold_cnt_d = hold_cnt_d + 8'd1;
				if (hold_cnt_d >= cfg.single_hold_frames) begin
					holding_d  = 1'b0;
					hold_cnt_d = 8'd0;
					led_d      = rgoc_pkg::LED_GREEN;
					if (hold_prev_d != rgoc_pkg::ST_DOUBLE && cnt_s_d != '1)
						cnt_s_d = cnt_s_d + rgoc_pkg::CNT_ONE;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cand_q      <= rgoc_pkg::ST_NONE;
			run_q       <= 4'd0;
			conf_q      <= rgoc_pkg::ST_NONE;
			prev_conf_q <= rgoc_pkg::ST_NONE;
			holding_q   <= 1'b0;
			hold_cnt_q  <= 8'd0;
			hold_prev_q <= rgoc_pkg::ST_NONE;
			stop_q      <= 1'b0;
			led_q       <= rgoc_pkg::LED_OFF;
			cnt_e_q     <= '0;
			cnt_s_q     <= '0;
			cnt_d_q     <= '0;
		end else if (upd_en) begin
			cand_q      <= cand_d;
			run_q       <= run_d;
			conf_q      <= conf_d;
			prev_conf_q <= prev_conf_d;
			holding_q   <= holding_d;
			hold_cnt_q  <= hold_cnt_d;
			hold_prev_q <= hold_prev_d;
			stop_q      <= stop_d;
			led_q       <= led_d;
			cnt_e_q     <= cnt_e_d;
			cnt_s_q     <= cnt_s_d;
			cnt_d_q     <= cnt_d_d;
		end
	end

	// status as it stands after this beat
	always_comb begin
		status.confirmed    = conf_d;
		status.led_select   = led_d;
		status.stop_flag    = stop_d;
		status.empty_count  = cnt_e_d;
		status.single_count = cnt_s_d;
		status.double_count = cnt_d_d;
	end

endmodule

FILE: hw/rtl/rgoc_checker.sv
// port-level checks of the range grid object classifier and their bind
module rgoc_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [95:0] s_tdata,
	input  logic [2:0]  s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [55:0] m_tdata,
	input  logic        m_tlast,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [11:0] cfg_wdata
);

	// a stalled result beat stays offered
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result beat dropped while stalled");

	// stop flag is sticky once shown
	a_stop_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[6] |=> m_tdata[6])
		else $error("stop flag cleared");

	// rows that do not end a frame carry no frame class
	a_class_idle: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> m_tdata[1:0] == 2'd0)
		else $error("frame class on a non-frame beat");

	// a confirmed double always shows the blue lamp
	a_double_led: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[3:2] == 2'd3 |-> m_tdata[5:4] == 2'd3)
		else $error("confirmed double without blue lamp");

endmodule

bind range_grid_object_classifier rgoc_checker u_rgoc_checker (.*);
